FILE: rtl/vtd_pkg.sv
// shared constants and control types of the vertex triple dedup block
`default_nettype none

package vtd_pkg;

    localparam int MAX_UNIQUE = 4096;
    localparam int INDEX_BITS = 20;
    localparam int FIELD_W    = 20;
    localparam int ID_W       = 12;
    localparam int ADDR_W     = $clog2(MAX_UNIQUE);
    localparam int CNT_W      = $clog2(MAX_UNIQUE + 1);
    localparam int ENTRY_W    = 3 * INDEX_BITS;

    typedef logic [INDEX_BITS-1:0] t_idx;
    typedef logic [ADDR_W-1:0]     t_addr;
    typedef logic [CNT_W-1:0]      t_cnt;
    typedef logic [ENTRY_W-1:0]    t_entry;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic scan;
        logic commit;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic match;
        logic scan_end;
        logic out_free;
    } t_dp_status;

endpackage

`default_nettype wire

FILE: rtl/vtd_in_if.sv
// corner input channel
`default_nettype none

interface vtd_in_if;
    logic                         valid;
    logic                         ready;
    logic [vtd_pkg::FIELD_W-1:0]  position_index;
    logic [vtd_pkg::FIELD_W-1:0]  texcoord_index;
    logic [vtd_pkg::FIELD_W-1:0]  normal_index;
    logic                         last_corner;

    modport source (
        output valid, position_index, texcoord_index, normal_index, last_corner,
        input  ready
    );
    modport sink (
        input  valid, position_index, texcoord_index, normal_index, last_corner,
        output ready
    );
endinterface

`default_nettype wire

FILE: rtl/vtd_out_if.sv
// vertex id result channel
`default_nettype none

interface vtd_out_if;
    logic                         valid;
    logic                         ready;
    logic [vtd_pkg::ID_W-1:0]     vertex_id;
    logic                         is_new;
    logic [vtd_pkg::FIELD_W-1:0]  src_position;
    logic [vtd_pkg::FIELD_W-1:0]  src_texcoord;
    logic [vtd_pkg::FIELD_W-1:0]  src_normal;
    logic                         overflow;
    logic                         bad_index;
    logic                         mesh_done;

    modport source (
        output valid, vertex_id, is_new, src_position, src_texcoord, src_normal,
               overflow, bad_index, mesh_done,
        input  ready
    );
    modport sink (
        input  valid, vertex_id, is_new, src_position, src_texcoord, src_normal,
               overflow, bad_index, mesh_done,
        output ready
    );
endinterface

`default_nettype wire

FILE: rtl/vtd_ram.sv
// generic single port ram with registered read
`default_nettype none

module vtd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end

endmodule

`default_nettype wire

FILE: rtl/vtd_ctrl.sv
// controller state machine: capture, table scan, result commit
`default_nettype none

module vtd_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    input  wire vtd_pkg::t_dp_status i_status,
    output logic                 o_in_ready,
    output vtd_pkg::t_dp_cmd     o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SEARCH = 3'b010,
        S_FINISH = 3'b100
    } t_state;

    t_state r_state, n_state;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state      = r_state;
        o_cmd        = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_SEARCH;
                end
            end
            S_SEARCH: begin
                o_cmd.scan = 1'b1;
                if (i_status.match || i_status.scan_end) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (i_status.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/vtd_dp.sv
// datapath: corner register, triple table, scan counters, result register
`default_nettype none

module vtd_dp (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    vtd_in_if.sink                i_corner,
    vtd_out_if.source             o_vertex,
    input  wire vtd_pkg::t_dp_cmd i_cmd,
    output vtd_pkg::t_dp_status   o_status
);

    vtd_pkg::t_idx  r_pos, r_tex, r_nrm;
    logic           r_last;
    vtd_pkg::t_cnt  r_count, n_count;
    vtd_pkg::t_cnt  r_addr;
    logic           r_pend;
    vtd_pkg::t_addr r_cmp_addr;
    logic           r_hit;
    vtd_pkg::t_addr r_hit_addr;
    logic           r_out_valid;

    logic             w_bad;
    logic             w_issue;
    logic             w_full;
    logic             w_insert;
    vtd_pkg::t_addr   w_ram_addr;
    vtd_pkg::t_entry  w_rdata;

    assign w_bad    = (r_pos == '0) || (r_tex == '0) || (r_nrm == '0);
    assign w_issue  = i_cmd.scan && !w_bad && (r_addr < r_count);
    assign w_full   = (r_count >= vtd_pkg::CNT_W'(vtd_pkg::MAX_UNIQUE));
    assign w_insert = i_cmd.commit && !w_bad && !r_hit && !w_full;

    // the single port appends at the fill count on commit, else walks the scan address
    assign w_ram_addr = i_cmd.commit ? r_count[vtd_pkg::ADDR_W-1:0]
                                     : r_addr[vtd_pkg::ADDR_W-1:0];

    vtd_ram #(
        .WIDTH (vtd_pkg::ENTRY_W),
        .DEPTH (vtd_pkg::MAX_UNIQUE)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_insert),
        .i_addr  (w_ram_addr),
        .i_wdata ({r_pos, r_tex, r_nrm}),
        .o_rdata (w_rdata)
    );

    assign o_status.match    = r_pend && (w_rdata == {r_pos, r_tex, r_nrm});
    assign o_status.scan_end = !w_issue && !r_pend;
    assign o_status.out_free = !r_out_valid || o_vertex.ready;

    always_comb begin
        n_count = r_count;
        if (w_insert) begin
            n_count = r_count + vtd_pkg::CNT_W'(1);
        end
        if (i_cmd.commit && r_last) begin
            n_count = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_pos  <= i_corner.position_index[vtd_pkg::INDEX_BITS-1:0];
            r_tex  <= i_corner.texcoord_index[vtd_pkg::INDEX_BITS-1:0];
            r_nrm  <= i_corner.normal_index[vtd_pkg::INDEX_BITS-1:0];
            r_last <= i_corner.last_corner;
        end
        if (w_issue) begin
            r_cmp_addr <= r_addr[vtd_pkg::ADDR_W-1:0];
        end
        // earliest hit wins: later reads issued after it are ignored
        if (i_cmd.scan && o_status.match && !r_hit) begin
            r_hit_addr <= r_cmp_addr;
        end
        if (i_cmd.commit) begin
            o_vertex.vertex_id    <= '0;
            o_vertex.is_new       <= 1'b0;
            o_vertex.src_position <= '0;
            o_vertex.src_texcoord <= '0;
            o_vertex.src_normal   <= '0;
            o_vertex.overflow     <= 1'b0;
            o_vertex.bad_index    <= w_bad;
            o_vertex.mesh_done    <= r_last;
            if (!w_bad) begin
                if (r_hit) begin
                    o_vertex.vertex_id <= vtd_pkg::ID_W'(r_hit_addr);
                end else if (w_full) begin
                    o_vertex.overflow <= 1'b1;
                end else begin
                    o_vertex.vertex_id    <= vtd_pkg::ID_W'(r_count[vtd_pkg::ADDR_W-1:0]);
                    o_vertex.is_new       <= 1'b1;
                    o_vertex.src_position <= vtd_pkg::FIELD_W'(r_pos - vtd_pkg::INDEX_BITS'(1));
                    o_vertex.src_texcoord <= vtd_pkg::FIELD_W'(r_tex - vtd_pkg::INDEX_BITS'(1));
                    o_vertex.src_normal   <= vtd_pkg::FIELD_W'(r_nrm - vtd_pkg::INDEX_BITS'(1));
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_addr      <= '0;
            r_pend      <= 1'b0;
            r_hit       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (i_cmd.capture) begin
                r_addr <= '0;
                r_pend <= 1'b0;
                r_hit  <= 1'b0;
            end else begin
                if (w_issue) begin
                    r_addr <= r_addr + vtd_pkg::CNT_W'(1);
                end
                r_pend <= w_issue;
                if (i_cmd.scan && o_status.match) begin
                    r_hit <= 1'b1;
                end
            end
            if (i_cmd.commit) begin
                r_out_valid <= 1'b1;
            end else if (o_vertex.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_vertex.valid = r_out_valid;

endmodule

`default_nettype wire

FILE: rtl/vertex_triple_dedup_top.sv
// top level of the vertex triple dedup block
// i_corner takes one face corner per transaction: three one-based indices
// and a last_corner mark. o_vertex gives one result per corner, in order:
// the vertex id, is_new with zero-based source indices for a first-seen
// triple, overflow, bad_index and mesh_done.
// a corner is searched against the table of distinct triples one entry per
// cycle through the single port of the table ram. a miss reads all N stored
// triples (at most 4096); a hit on entry j ends the search at that entry;
// a corner with a zero index or an empty table skips the search.
// one corner is worked on at a time; the next is accepted as soon as the
// previous result sits in the output register, even if it is not yet taken.
// when the receiver stalls, a finished result waits in the output register
// and the block holds the following corner until that register frees.
// reset empties the table (fill count to zero) and drops any pending
// result; table contents are not cleared, only entries below the fill count
// are ever read. a corner marked last_corner empties the table after it.
`default_nettype none

module vertex_triple_dedup_top (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    vtd_in_if.sink    i_corner,
    vtd_out_if.source o_vertex
);

    vtd_pkg::t_dp_cmd    w_cmd;
    vtd_pkg::t_dp_status w_status;
    logic                w_ready;

    assign i_corner.ready = w_ready;

    vtd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_corner.valid),
        .i_status   (w_status),
        .o_in_ready (w_ready),
        .o_cmd      (w_cmd)
    );

    vtd_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_corner (i_corner),
        .o_vertex (o_vertex),
        .i_cmd    (w_cmd),
        .o_status (w_status)
    );

endmodule

`default_nettype wire

FILE: bench/vertex_triple_dedup_top_test.sv
// testbench for the vertex triple dedup top level: directed and random corners checked in order
`timescale 1ns / 100ps

module vertex_triple_dedup_top_test;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int RANDOM_CORNERS = 124;
    localparam int SETTLE_CYCLES  = 20;

    typedef logic [vtd_pkg::FIELD_W-1:0] t_field;

    typedef struct {
        t_field pos;
        t_field tex;
        t_field nrm;
        logic   last;
        bit     hold;   // sender waits until every result is back
    } t_corner;

    typedef struct {
        logic [vtd_pkg::ID_W-1:0] vertex_id;
        logic                     is_new;
        t_field                   src_pos;
        t_field                   src_tex;
        t_field                   src_nrm;
        logic                     overflow;
        logic                     bad_index;
        logic                     mesh_done;
    } t_vertex;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    vtd_in_if  corner_if();
    vtd_out_if vertex_if();

    vertex_triple_dedup_top DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_corner (corner_if),
        .o_vertex (vertex_if)
    );

    always #1 i_clk = ~i_clk;

    t_corner corner_queue[$];
    t_vertex vertex_expect[$];

    // predictor state: distinct triples of the current mesh
    vtd_pkg::t_idx seen_pos [vtd_pkg::MAX_UNIQUE];
    vtd_pkg::t_idx seen_tex [vtd_pkg::MAX_UNIQUE];
    vtd_pkg::t_idx seen_nrm [vtd_pkg::MAX_UNIQUE];
    int            seen_count = 0;

    bit corner_taken = 1'b0;
    bit vertex_taken = 1'b0;
    bit calm         = 1'b0;   // stretch with no idling on either side
    int send_gap     = 0;
    int stall_left   = 0;
    int idle_cycles  = 0;
    int errors       = 0;
    int n_corners    = 0;
    int n_new        = 0;
    int n_hit        = 0;
    int n_bad        = 0;
    int n_full       = 0;
    int n_meshes     = 0;

    function automatic t_vertex predict_vertex(t_corner c);
        t_vertex       v;
        vtd_pkg::t_idx p;
        vtd_pkg::t_idx t;
        vtd_pkg::t_idx n;
        int            hit;
        p   = c.pos[vtd_pkg::INDEX_BITS-1:0];
        t   = c.tex[vtd_pkg::INDEX_BITS-1:0];
        n   = c.nrm[vtd_pkg::INDEX_BITS-1:0];
        v   = '{default: '0};
        hit = -1;
        if (p == '0 || t == '0 || n == '0) begin
            v.bad_index = 1'b1;
        end else begin
            for (int i = 0; i < seen_count && hit < 0; i++) begin
                if (seen_pos[i] == p && seen_tex[i] == t && seen_nrm[i] == n) begin
                    hit = i;
                end
            end
            if (hit >= 0) begin
                v.vertex_id = vtd_pkg::ID_W'(hit);
            end else if (seen_count >= vtd_pkg::MAX_UNIQUE) begin
                v.overflow = 1'b1;
            end else begin
                seen_pos[seen_count] = p;
                seen_tex[seen_count] = t;
                seen_nrm[seen_count] = n;
                v.vertex_id = vtd_pkg::ID_W'(seen_count);
                v.is_new    = 1'b1;
                v.src_pos   = vtd_pkg::FIELD_W'(vtd_pkg::t_idx'(p - 1'b1));
                v.src_tex   = vtd_pkg::FIELD_W'(vtd_pkg::t_idx'(t - 1'b1));
                v.src_nrm   = vtd_pkg::FIELD_W'(vtd_pkg::t_idx'(n - 1'b1));
                seen_count++;
            end
        end
        if (c.last) begin
            seen_count = 0;
        end
        v.mesh_done = c.last;
        return v;
    endfunction

    function automatic int draw_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm) return 0;
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic t_field draw_index();
        case ($urandom_range(0, 7))
            0, 1:    return t_field'($urandom_range(1, 8));
            2:       return {vtd_pkg::FIELD_W{1'b1}};
            default: return t_field'($urandom_range(1, (1 << vtd_pkg::FIELD_W) - 1));
        endcase
    endfunction

    task automatic queue_corner(input t_field p, input t_field t, input t_field n,
                                input logic last, input bit hold = 1'b0);
        t_corner c;
        c.pos  = p;
        c.tex  = t;
        c.nrm  = n;
        c.last = last;
        c.hold = hold;
        corner_queue.push_back(c);
    endtask

    task automatic check_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t mismatch %s: expected 0x%0h actual 0x%0h", $time, what, want, got);
            errors++;
        end
    endtask

    // corner driver
    always @(negedge i_clk) begin
        t_corner c;
        if (i_rst_n) begin
            if (corner_if.valid && !corner_taken) begin
                // transaction still pending, hold it
            end else if (send_gap > 0) begin
                send_gap = send_gap - 1;
                corner_if.valid <= 1'b0;
            end else if (corner_queue.size() != 0 &&
                         !(corner_queue[0].hold && vertex_expect.size() != 0)) begin
                c = corner_queue.pop_front();
                corner_if.valid          <= 1'b1;
                corner_if.position_index <= c.pos;
                corner_if.texcoord_index <= c.tex;
                corner_if.normal_index   <= c.nrm;
                corner_if.last_corner    <= c.last;
                send_gap = draw_gap();
            end else begin
                corner_if.valid <= 1'b0;
            end
        end
    end

    // result backpressure
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left = stall_left - 1;
            vertex_if.ready <= 1'b0;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
            stall_left = draw_gap();
            vertex_if.ready <= (stall_left == 0);
        end else begin
            vertex_if.ready <= 1'b1;
        end
    end

    // monitor and scoreboard
    always @(posedge i_clk) begin
        t_corner c;
        t_vertex got;
        t_vertex want;
        corner_taken = i_rst_n && corner_if.valid && corner_if.ready;
        vertex_taken = i_rst_n && vertex_if.valid && vertex_if.ready;
        if (corner_taken) begin
            c.pos  = corner_if.position_index;
            c.tex  = corner_if.texcoord_index;
            c.nrm  = corner_if.normal_index;
            c.last = corner_if.last_corner;
            c.hold = 1'b0;
            want = predict_vertex(c);
            vertex_expect.push_back(want);
            n_corners++;
            n_new    += want.is_new;
            n_bad    += want.bad_index;
            n_full   += want.overflow;
            n_meshes += want.mesh_done;
            if (!want.is_new && !want.bad_index && !want.overflow) n_hit++;
            if ($urandom_range(0, 39) == 0) calm = !calm;
        end
        if (vertex_taken) begin
            got.vertex_id = vertex_if.vertex_id;
            got.is_new    = vertex_if.is_new;
            got.src_pos   = vertex_if.src_position;
            got.src_tex   = vertex_if.src_texcoord;
            got.src_nrm   = vertex_if.src_normal;
            got.overflow  = vertex_if.overflow;
            got.bad_index = vertex_if.bad_index;
            got.mesh_done = vertex_if.mesh_done;
            if (vertex_expect.size() == 0) begin
                $display("%0t unexpected result: expected none actual id 0x%0h",
                         $time, got.vertex_id);
                errors++;
            end else begin
                want = vertex_expect.pop_front();
                check_field("vertex_id", 32'(want.vertex_id), 32'(got.vertex_id));
                check_field("is_new", 32'(want.is_new), 32'(got.is_new));
                check_field("src_position", 32'(want.src_pos), 32'(got.src_pos));
                check_field("src_texcoord", 32'(want.src_tex), 32'(got.src_tex));
                check_field("src_normal", 32'(want.src_nrm), 32'(got.src_nrm));
                check_field("overflow", 32'(want.overflow), 32'(got.overflow));
                check_field("bad_index", 32'(want.bad_index), 32'(got.bad_index));
                check_field("mesh_done", 32'(want.mesh_done), 32'(got.mesh_done));
            end
        end
        if (corner_taken || vertex_taken || !i_rst_n) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t watchdog: no transaction for %0d cycles, %0d results outstanding",
                     $time, idle_cycles, vertex_expect.size());
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        t_field pool_p [6];
        t_field pool_t [6];
        t_field pool_n [6];
        int     pool_size;
        int     mesh_len;
        int     pick;
        int     r;
        int     random_count;
        t_field p;
        t_field t;
        t_field n;
        logic   last;

        corner_if.valid          = 1'b0;
        corner_if.position_index = '0;
        corner_if.texcoord_index = '0;
        corner_if.normal_index   = '0;
        corner_if.last_corner    = 1'b0;
        vertex_if.ready          = 1'b0;

        // directed: first sighting, repeat, extremes, each zero index, clear on last
        queue_corner(1, 1, 1, 1'b0);
        queue_corner(1, 1, 1, 1'b0);
        queue_corner({vtd_pkg::FIELD_W{1'b1}}, {vtd_pkg::FIELD_W{1'b1}},
                     {vtd_pkg::FIELD_W{1'b1}}, 1'b0);
        queue_corner(0, 5, 5, 1'b0);
        queue_corner(5, 0, 5, 1'b0);
        queue_corner(5, 5, 0, 1'b0);
        queue_corner(1, 1, 2, 1'b0);
        queue_corner(2, 1, 1, 1'b0);
        queue_corner(1, 2, 1, 1'b0);
        queue_corner({vtd_pkg::FIELD_W{1'b1}}, {vtd_pkg::FIELD_W{1'b1}},
                     {vtd_pkg::FIELD_W{1'b1}}, 1'b0);
        queue_corner(1, 1, 1, 1'b1);
        queue_corner(1, 1, 1, 1'b0);
        queue_corner(0, 0, 0, 1'b1);
        queue_corner({vtd_pkg::FIELD_W{1'b1}}, 1, {vtd_pkg::FIELD_W{1'b1}}, 1'b1);
        queue_corner(3, 3, 3, 1'b0, 1'b1);
        queue_corner(3, 3, 3, 1'b1);

        // random meshes built mostly from a small pool so repeats are common
        random_count = 0;
        while (random_count < RANDOM_CORNERS) begin
            pool_size = $urandom_range(1, 6);
            for (int k = 0; k < pool_size; k++) begin
                pool_p[k] = draw_index();
                pool_t[k] = draw_index();
                pool_n[k] = draw_index();
            end
            mesh_len = $urandom_range(1, 16);
            for (int k = 0; k < mesh_len; k++) begin
                r    = $urandom_range(0, 99);
                pick = $urandom_range(0, pool_size - 1);
                p    = pool_p[pick];
                t    = pool_t[pick];
                n    = pool_n[pick];
                if (r >= 70 && r < 85) begin
                    p = draw_index();
                    t = draw_index();
                    n = draw_index();
                end else if (r >= 85 && r < 93) begin
                    case ($urandom_range(0, 3))
                        0: p = '0;
                        1: t = '0;
                        2: n = '0;
                        default: begin
                            p = '0;
                            n = '0;
                        end
                    endcase
                end else if (r >= 93) begin
                    p = t_field'($urandom());
                    t = t_field'($urandom());
                    n = t_field'($urandom());
                end
                // an occasional mesh runs on into the next without a last mark
                last = (k == mesh_len - 1) && ($urandom_range(0, 9) != 0);
                queue_corner(p, t, n, last, random_count == RANDOM_CORNERS / 2);
                random_count++;
            end
        end

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (corner_queue.size() != 0 || (corner_if.valid && !corner_taken)) begin
            @(negedge i_clk);
        end
        while (vertex_expect.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);

        $display("covered %0d corners over %0d meshes with random idling and result stalls",
                 n_corners, n_meshes);
        $display("results: %0d new, %0d repeated, %0d zero index, %0d table full, %0d errors",
                 n_new, n_hit, n_bad, n_full, errors);
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
